// File: src/depth_frame_obstacle_sectors_unit_assert.svh
// Assertion helpers for the obstacle sector block.
`ifndef DEPTH_FRAME_OBSTACLE_SECTORS_UNIT_ASSERT_SVH
`define DEPTH_FRAME_OBSTACLE_SECTORS_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DFOS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfos assertion failed");

// antecedent implies consequent in the next cycle
`define DFOS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfos assertion failed");

`endif

// File: src/dfos_pkg.sv
package dfos_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int DEPTH_BITS  = 16;
   localparam int DIM_BITS    = 13;
   localparam int CNT_BITS    = 12;
   localparam int FOV_BITS    = 13;
   localparam int CSR_IDX_BITS = 4;
   localparam int CSR_DATA_BITS = 16;

   // signed column offset, product and sector limit widths
   localparam int OFS_BITS    = CNT_BITS + 3;
   localparam int PROD_BITS   = OFS_BITS + FOV_BITS + 1;
   localparam int LIM_BITS    = CNT_BITS + 9;

   // 15 degrees in sixteenths, times two for the doubled column offset
   localparam int AHEAD_SCALE = 480;

   localparam logic [DIM_BITS-1:0]   WIDTH_RESET     = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET    = DIM_BITS'(480);
   localparam logic [DEPTH_BITS-1:0] THRESHOLD_RESET = DEPTH_BITS'(1000);
   localparam logic [FOV_BITS-1:0]   FOV_RESET       = FOV_BITS'(1392);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 4'd0,
      CSR_FRAME_HEIGHT = 4'd1,
      CSR_THRESHOLD    = 4'd2,
      CSR_FOV          = 4'd3
   } csr_index_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (v > DIM_BITS'(MAX_DIM)) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: src/dfos_channels_if.sv
interface dfos_req_if import dfos_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DEPTH_BITS-1:0] depth_mm;
   logic                  depth_valid;

   modport source (output valid, output depth_mm, output depth_valid, input ready);
   modport sink   (input valid, input depth_mm, input depth_valid, output ready);
endinterface

interface dfos_rsp_if import dfos_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DEPTH_BITS-1:0] nearest_mm;
   logic                  obstacle_ahead;
   logic                  obstacle_left;
   logic                  obstacle_right;

   modport source (output valid, output nearest_mm, output obstacle_ahead,
                   output obstacle_left, output obstacle_right, input ready);
   modport sink   (input valid, input nearest_mm, input obstacle_ahead,
                   input obstacle_left, input obstacle_right, output ready);
endinterface

interface dfos_csr_if import dfos_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/depth_frame_obstacle_sectors_unit.sv
// Depth frame obstacle sectors.
// req_ch carries depth pixels in raster order (columns fastest): depth_mm and
// depth_valid. Zero depth counts as invalid. The block counts column and row
// itself, keeps the nearest valid depth and raises ahead, left or right when a
// valid pixel at or below threshold_mm lies within, below or above 15 degrees.
// rsp_ch delivers one result per frame, on the frame's last pixel: nearest_mm
// (0 if no valid pixel) and the three flags; frame state then clears.
// csr_ch writes frame_width, frame_height, threshold_mm and fov_sixteenths at
// indexes 0 to 3, always ready; write only while the block is idle.
// Throughput: one pixel per cycle, but for a frame's last pixel held by a stalled
// rsp_ch. A pixel is captured in the input register, and the sector multiply and
// compares then update the frame state from that register; a frame's result is
// loaded into the output register when its last pixel leaves the input register.
// When rsp_ch stalls, non-final pixels keep flowing; a frame's last pixel waits
// in the input register until the output register is free, and req_ch.ready
// stays low meanwhile.
// Reset (synchronous, active high) restores register defaults, clears counters,
// flags and both pipeline valids.
`include "depth_frame_obstacle_sectors_unit_assert.svh"

module depth_frame_obstacle_sectors_unit import dfos_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dfos_req_if.sink   req_ch,
   dfos_rsp_if.source rsp_ch,
   dfos_csr_if.sink   csr_ch
);

   logic [DIM_BITS-1:0]   width_ff;
   logic [DIM_BITS-1:0]   height_ff;
   logic [DEPTH_BITS-1:0] threshold_ff;
   logic [FOV_BITS-1:0]   fov_ff;

   logic [CNT_BITS-1:0]   col_ff, col_in;
   logic [CNT_BITS-1:0]   row_ff, row_in;

   logic                  p1_valid_ff;
   logic [DEPTH_BITS-1:0] p1_depth_ff;
   logic                  p1_dvalid_ff;
   logic [CNT_BITS-1:0]   p1_col_ff;
   logic                  p1_last_ff;

   logic [DEPTH_BITS-1:0] nearest_ff, nearest_in;
   logic                  seen_ff, seen_in;
   logic                  ahead_ff, ahead_in;
   logic                  left_ff, left_in;
   logic                  right_ff, right_in;

   logic                  rsp_valid_ff;
   logic [DEPTH_BITS-1:0] rsp_nearest_ff;
   logic                  rsp_ahead_ff;
   logic                  rsp_left_ff;
   logic                  rsp_right_ff;

   logic [DIM_BITS-1:0]   w_eff;
   logic [DIM_BITS-1:0]   h_eff;
   logic                  last_col;
   logic                  last_row;
   logic                  req_fire;
   logic                  p1_advance;

   logic [CNT_BITS-1:0]          w_m1;
   logic [CNT_BITS-1:0]          m_val;
   logic signed [OFS_BITS-1:0]   offset;
   logic signed [PROD_BITS-1:0]  prod;
   logic [LIM_BITS-1:0]          lim;
   logic signed [PROD_BITS-1:0]  lim_s;
   logic                         pix_ok;
   logic                         near_pix;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         threshold_ff <= THRESHOLD_RESET;
         fov_ff       <= FOV_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FRAME_WIDTH:  width_ff     <= csr_ch.data[DIM_BITS-1:0];
            CSR_FRAME_HEIGHT: height_ff    <= csr_ch.data[DIM_BITS-1:0];
            CSR_THRESHOLD:    threshold_ff <= csr_ch.data[DEPTH_BITS-1:0];
            CSR_FOV:          fov_ff       <= csr_ch.data[FOV_BITS-1:0];
            default: ;
         endcase
      end
   end

   // position tracking at capture time
   always_comb begin
      w_eff    = clamp_dim(width_ff);
      h_eff    = clamp_dim(height_ff);
      last_col = ({1'b0, col_ff} + DIM_BITS'(1)) >= w_eff;
      last_row = ({1'b0, row_ff} + DIM_BITS'(1)) >= h_eff;

      p1_advance = p1_valid_ff && (!p1_last_ff || !rsp_valid_ff || rsp_ch.ready);
      req_ch.ready = !p1_valid_ff || p1_advance;
      req_fire = req_ch.valid && req_ch.ready;

      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (last_col && last_row) begin
            col_in = '0;
            row_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + CNT_BITS'(1);
         end else begin
            col_in = col_ff + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         p1_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (req_ch.ready) begin
            p1_valid_ff <= req_ch.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p1_depth_ff  <= req_ch.depth_mm;
         p1_dvalid_ff <= req_ch.depth_valid;
         p1_col_ff    <= col_ff;
         p1_last_ff   <= last_col && last_row;
      end
   end

   // sector test and frame accumulation
   always_comb begin
      w_m1   = CNT_BITS'(w_eff - DIM_BITS'(1));
      m_val  = (w_m1 == '0) ? CNT_BITS'(1) : w_m1;
      offset = $signed({2'b00, p1_col_ff, 1'b0}) - $signed({3'b000, w_m1});
      prod   = PROD_BITS'(PROD_BITS'(offset) * $signed({{(PROD_BITS-FOV_BITS){1'b0}}, fov_ff}));
      lim    = LIM_BITS'(LIM_BITS'(m_val) * LIM_BITS'(AHEAD_SCALE));
      lim_s  = $signed({{(PROD_BITS-LIM_BITS){1'b0}}, lim});

      pix_ok   = p1_dvalid_ff && (p1_depth_ff != '0);
      near_pix = pix_ok && (p1_depth_ff <= threshold_ff);

      seen_in    = seen_ff || pix_ok;
      nearest_in = (pix_ok && (p1_depth_ff < nearest_ff)) ? p1_depth_ff : nearest_ff;
      ahead_in   = ahead_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      if (near_pix) begin
         if ((prod >= -lim_s) && (prod <= lim_s)) begin
            ahead_in = 1'b1;
         end else if (prod < -lim_s) begin
            left_in = 1'b1;
         end else begin
            right_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nearest_ff <= '1;
         seen_ff    <= 1'b0;
         ahead_ff   <= 1'b0;
         left_ff    <= 1'b0;
         right_ff   <= 1'b0;
      end else if (p1_advance) begin
         if (p1_last_ff) begin
            nearest_ff <= '1;
            seen_ff    <= 1'b0;
            ahead_ff   <= 1'b0;
            left_ff    <= 1'b0;
            right_ff   <= 1'b0;
         end else begin
            nearest_ff <= nearest_in;
            seen_ff    <= seen_in;
            ahead_ff   <= ahead_in;
            left_ff    <= left_in;
            right_ff   <= right_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (p1_advance && p1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_advance && p1_last_ff) begin
         rsp_nearest_ff <= seen_in ? nearest_in : '0;
         rsp_ahead_ff   <= ahead_in;
         rsp_left_ff    <= left_in;
         rsp_right_ff   <= right_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.nearest_mm     = rsp_nearest_ff;
   assign rsp_ch.obstacle_ahead = rsp_ahead_ff;
   assign rsp_ch.obstacle_left  = rsp_left_ff;
   assign rsp_ch.obstacle_right = rsp_right_ff;

   `DFOS_ASSERT_NEXT(a_last_gives_rsp, clock, reset, p1_advance && p1_last_ff, rsp_valid_ff)
   `DFOS_ASSERT_NEXT(a_last_clears, clock, reset, p1_advance && p1_last_ff,
                     !seen_ff && !ahead_ff && !left_ff && !right_ff)
   `DFOS_ASSERT_NOW(a_empty_no_flags, clock, reset, rsp_valid_ff && (rsp_nearest_ff == '0),
                    !rsp_ahead_ff && !rsp_left_ff && !rsp_right_ff)
   `DFOS_ASSERT_NOW(a_unseen_nearest, clock, reset, !seen_ff, nearest_ff == '1)

endmodule
